@@ sv/tta_pkg.sv @@
// shared types and constants of the triangle tangent accumulator
package tta_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int COORD_W      = 32;
    localparam int SUM_W        = 48;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_TRI   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic [1:0]                func;
        logic [IDX_W-1:0]          index_a;
        logic [IDX_W-1:0]          index_b;
        logic [IDX_W-1:0]          index_c;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
    } in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] tangent_x;
        logic signed [SUM_W-1:0] tangent_y;
        logic signed [SUM_W-1:0] tangent_z;
        logic [1:0]              status;
    } out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
    } vtx_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } tan_t;

endpackage

@@ sv/tta_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module tta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ sv/triangle_tangent_accumulator.sv @@
// Triangle tangent accumulator: a vertex table in block ram with per-vertex tangent sums.
// A triangle does three vertex reads, eight products from one shared 33x33 multiplier,
// and per axis a bit-serial divider running 32 steps, skipped for an axis whose quotient
// overflows; the three corner sums are then updated by read-modify-write on the tangent
// ram one corner after another. A zero determinant ends the triangle with no sums updated.
// One request is in work at a time; the next is taken while a finished result still
// waits on m_.
module triangle_tangent_accumulator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tta_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tta_pkg::out_t m_data
);
    import tta_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LD_B, S_LD_C, S_LD_W, S_DELTA,
        S_DET0, S_DET1, S_DET2, S_DET3,
        S_NUM0, S_NUM1, S_NUM2, S_DPREP, S_DIV, S_DFIN,
        S_ACC_RD, S_ACC_WR, S_RDT, S_RESP
    } state_t;

    state_t state_reg;

    logic [IDX_W-1:0] ia_reg, ib_reg, ic_reg;
    vtx_t             va_reg, vb_reg, vc_reg;
    logic signed [32:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [32:0] d1_reg [3];
    logic signed [32:0] d2_reg [3];
    logic signed [31:0] t_reg [3];
    logic signed [65:0] prod_reg, first_reg;
    logic signed [66:0] det_reg, num_reg;
    logic [66:0] dabs_reg, rem_reg;
    logic [31:0] sh_reg, q_reg;
    logic [4:0]  step_reg;
    logic [1:0]  axis_reg, corner_reg;
    logic        neg_reg, ovf_reg, sat_reg;
    out_t        res_reg, m_data_reg;
    logic        m_valid_reg;

    logic accept;
    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // vertex ram
    logic             vtx_we, vtx_re;
    logic [IDX_W-1:0] vtx_raddr;
    vtx_t             vtx_wdata, vtx_rdata;

    assign vtx_we    = accept && (s_data.func == FUNC_WRITE);
    assign vtx_wdata = '{px: s_data.pos_x, py: s_data.pos_y, pz: s_data.pos_z,
                         u: s_data.tex_u, v: s_data.tex_v};
    assign vtx_re    = 1'b1;

    always_comb begin
        unique case (state_reg)
            S_LD_B:  vtx_raddr = ib_reg;
            S_LD_C:  vtx_raddr = ic_reg;
            default: vtx_raddr = s_data.index_a;
        endcase
    end

    tta_ram #(.WIDTH($bits(vtx_t)), .DEPTH(MAX_VERTICES)) u_vtx_ram (
        .clk(aclk), .we(vtx_we), .waddr(s_data.index_a), .wdata(vtx_wdata),
        .re(vtx_re), .raddr(vtx_raddr), .rdata(vtx_rdata)
    );

    // tangent ram
    logic             tan_we;
    logic [IDX_W-1:0] tan_waddr, tan_raddr, corner_idx;
    tan_t             tan_wdata, tan_rdata, tan_sum;
    logic [2:0]       tan_sat;

    always_comb begin
        unique case (corner_reg)
            2'd0:    corner_idx = ia_reg;
            2'd1:    corner_idx = ib_reg;
            default: corner_idx = ic_reg;
        endcase
    end

    function automatic logic [48:0] sat_add(logic signed [47:0] s, logic signed [31:0] t);
        logic signed [48:0] v;
        v = {s[47], s} + {{17{t[31]}}, t};
        if (v[48] != v[47]) begin
            return {1'b1, v[48], {47{~v[48]}}};
        end
        return {1'b0, v[47:0]};
    endfunction

    always_comb begin
        logic [48:0] rx, ry, rz;
        rx = sat_add(tan_rdata.x, t_reg[0]);
        ry = sat_add(tan_rdata.y, t_reg[1]);
        rz = sat_add(tan_rdata.z, t_reg[2]);
        tan_sum = '{x: rx[47:0], y: ry[47:0], z: rz[47:0]};
        tan_sat = {rx[48], ry[48], rz[48]};
    end

    assign tan_we    = vtx_we || (state_reg == S_ACC_WR);
    assign tan_waddr = (state_reg == S_ACC_WR) ? corner_idx : s_data.index_a;
    assign tan_wdata = (state_reg == S_ACC_WR) ? tan_sum : '0;
    assign tan_raddr = (state_reg == S_ACC_RD) ? corner_idx : s_data.index_a;

    tta_ram #(.WIDTH($bits(tan_t)), .DEPTH(MAX_VERTICES)) u_tan_ram (
        .clk(aclk), .we(tan_we), .waddr(tan_waddr), .wdata(tan_wdata),
        .re(1'b1), .raddr(tan_raddr), .rdata(tan_rdata)
    );

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    always_comb begin
        unique case (state_reg)
            S_DET1: begin
                mul_a = du2_reg;
                mul_b = dv1_reg;
            end
            S_NUM0: begin
                mul_a = d1_reg[axis_reg];
                mul_b = dv2_reg;
            end
            S_NUM1: begin
                mul_a = d2_reg[axis_reg];
                mul_b = dv1_reg;
            end
            default: begin
                mul_a = du1_reg;
                mul_b = dv2_reg;
            end
        endcase
    end

    function automatic logic signed [32:0] sdiff(logic signed [31:0] a, logic signed [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    // divider step
    logic [67:0] div_r2;
    logic        div_ge;
    logic [66:0] nabs;
    assign div_r2 = {rem_reg, sh_reg[31]};
    assign div_ge = div_r2 >= {1'b0, dabs_reg};
    assign nabs   = num_reg[66] ? 67'(-num_reg) : 67'(num_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            prod_reg <= mul_a * mul_b;
            if (state_reg == S_RESP && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        ia_reg  <= s_data.index_a;
                        ib_reg  <= s_data.index_b;
                        ic_reg  <= s_data.index_c;
                        res_reg <= '0;
                        sat_reg <= 1'b0;
                        unique case (s_data.func)
                            FUNC_TRI:  state_reg <= S_LD_B;
                            FUNC_READ: state_reg <= S_RDT;
                            default:   state_reg <= S_RESP;
                        endcase
                    end
                end
                S_LD_B: begin
                    va_reg    <= vtx_rdata;
                    state_reg <= S_LD_C;
                end
                S_LD_C: begin
                    vb_reg    <= vtx_rdata;
                    state_reg <= S_LD_W;
                end
                S_LD_W: begin
                    vc_reg    <= vtx_rdata;
                    state_reg <= S_DELTA;
                end
                S_DELTA: begin
                    du1_reg   <= sdiff(vb_reg.u, va_reg.u);
                    dv1_reg   <= sdiff(vb_reg.v, va_reg.v);
                    du2_reg   <= sdiff(vc_reg.u, va_reg.u);
                    dv2_reg   <= sdiff(vc_reg.v, va_reg.v);
                    d1_reg[0] <= sdiff(vb_reg.px, va_reg.px);
                    d1_reg[1] <= sdiff(vb_reg.py, va_reg.py);
                    d1_reg[2] <= sdiff(vb_reg.pz, va_reg.pz);
                    d2_reg[0] <= sdiff(vc_reg.px, va_reg.px);
                    d2_reg[1] <= sdiff(vc_reg.py, va_reg.py);
                    d2_reg[2] <= sdiff(vc_reg.pz, va_reg.pz);
                    state_reg <= S_DET0;
                end
                S_DET0: state_reg <= S_DET1;
                S_DET1: begin
                    first_reg <= prod_reg;
                    state_reg <= S_DET2;
                end
                S_DET2: begin
                    det_reg   <= {first_reg[65], first_reg} - {prod_reg[65], prod_reg};
                    state_reg <= S_DET3;
                end
                S_DET3: begin
                    dabs_reg <= det_reg[66] ? 67'(-det_reg) : 67'(det_reg);
                    axis_reg <= 2'd0;
                    if (det_reg == '0) begin
                        res_reg.status <= ST_DEGEN;
                        state_reg      <= S_RESP;
                    end else begin
                        state_reg <= S_NUM0;
                    end
                end
                S_NUM0: state_reg <= S_NUM1;
                S_NUM1: begin
                    first_reg <= prod_reg;
                    state_reg <= S_NUM2;
                end
                S_NUM2: begin
                    num_reg   <= {first_reg[65], first_reg} - {prod_reg[65], prod_reg};
                    state_reg <= S_DPREP;
                end
                S_DPREP: begin
                    neg_reg   <= num_reg[66] ^ det_reg[66];
                    ovf_reg   <= {16'd0, nabs} >= {dabs_reg, 16'd0};
                    rem_reg   <= {16'd0, nabs[66:16]};
                    sh_reg    <= {nabs[15:0], 16'd0};
                    q_reg     <= '0;
                    step_reg  <= '0;
                    state_reg <= ({16'd0, nabs} >= {dabs_reg, 16'd0}) ? S_DFIN : S_DIV;
                end
                S_DIV: begin
                    rem_reg  <= div_ge ? 67'(div_r2 - {1'b0, dabs_reg}) : div_r2[66:0];
                    sh_reg   <= {sh_reg[30:0], 1'b0};
                    q_reg    <= {q_reg[30:0], div_ge};
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31) begin
                        state_reg <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    if (neg_reg) begin
                        if (ovf_reg || (q_reg[31] && q_reg[30:0] != '0)) begin
                            t_reg[axis_reg] <= 32'sh8000_0000;
                            sat_reg         <= 1'b1;
                        end else begin
                            t_reg[axis_reg] <= -q_reg;
                        end
                    end else begin
                        if (ovf_reg || q_reg[31]) begin
                            t_reg[axis_reg] <= 32'sh7fff_ffff;
                            sat_reg         <= 1'b1;
                        end else begin
                            t_reg[axis_reg] <= q_reg;
                        end
                    end
                    corner_reg <= 2'd0;
                    axis_reg   <= axis_reg + 2'd1;
                    state_reg  <= (axis_reg == 2'd2) ? S_ACC_RD : S_NUM0;
                end
                S_ACC_RD: state_reg <= S_ACC_WR;
                S_ACC_WR: begin
                    if (tan_sat != '0) begin
                        sat_reg <= 1'b1;
                    end
                    corner_reg <= corner_reg + 2'd1;
                    if (corner_reg == 2'd2) begin
                        res_reg.status <= (sat_reg || tan_sat != '0) ? ST_SAT : ST_OK;
                        state_reg      <= S_RESP;
                    end else begin
                        state_reg <= S_ACC_RD;
                    end
                end
                S_RDT: begin
                    res_reg.tangent_x <= tan_rdata.x;
                    res_reg.tangent_y <= tan_rdata.y;
                    res_reg.tangent_z <= tan_rdata.z;
                    state_reg         <= S_RESP;
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> rem_reg < dabs_reg)
        else $error("divider remainder not below divisor");

    a_div_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> !ovf_reg)
        else $error("divider running on overflowed quotient");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DET3 && det_reg == '0) |=>
            (state_reg == S_RESP && res_reg.status == ST_DEGEN))
        else $error("zero determinant not flagged");

    a_acc_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ACC_WR |=> (state_reg == S_ACC_RD || state_reg == S_RESP))
        else $error("corner update sequence broken");

endmodule

@@ verif/triangle_tangent_accumulator_tb.sv @@
// triangle tangent accumulator bench: directed and random requests, checked against a predictor
`timescale 1ns / 1ps

module triangle_tangent_accumulator_tb;
    import tta_pkg::*;

    class tangent_scoreboard;
        logic signed [31:0] px [MAX_VERTICES];
        logic signed [31:0] py [MAX_VERTICES];
        logic signed [31:0] pz [MAX_VERTICES];
        logic signed [31:0] tu [MAX_VERTICES];
        logic signed [31:0] tv [MAX_VERTICES];
        longint sums [3][MAX_VERTICES];
        out_t pending_results[$];
        int errors;

        function new();
            errors = 0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
                px[i] = 0; py[i] = 0; pz[i] = 0; tu[i] = 0; tv[i] = 0;
                for (int k = 0; k < 3; k++) sums[k][i] = 0;
            end
        endfunction

        function longint clamp_sum(longint s, longint t, inout bit sat);
            longint v;
            v = s + t;
            if (v > 64'sd140737488355327) begin
                sat = 1;
                return 64'sd140737488355327;
            end
            if (v < -64'sd140737488355328) begin
                sat = 1;
                return -64'sd140737488355328;
            end
            return v;
        endfunction

        function longint tangent_q16(logic signed [127:0] num, logic signed [127:0] den,
                                     inout bit sat);
            logic [127:0] n, d, q;
            bit neg;
            neg = num[127] != den[127];
            n = num[127] ? -num : num;
            d = den[127] ? -den : den;
            q = (n << 16) / d;
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    sat = 1;
                    return -64'sd2147483648;
                end
                return -longint'(q[63:0]);
            end
            if (q > 128'h7fff_ffff) begin
                sat = 1;
                return 64'sd2147483647;
            end
            return longint'(q[63:0]);
        endfunction

        function void note(in_t r);
            out_t e;
            logic signed [127:0] du1, dv1, du2, dv2, d1, d2, det;
            longint p0, t;
            int corner[3];
            bit sat;
            e = '0;
            case (r.func)
                FUNC_WRITE: begin
                    px[r.index_a] = r.pos_x; py[r.index_a] = r.pos_y; pz[r.index_a] = r.pos_z;
                    tu[r.index_a] = r.tex_u; tv[r.index_a] = r.tex_v;
                    for (int k = 0; k < 3; k++) sums[k][r.index_a] = 0;
                end
                FUNC_READ: begin
                    e.tangent_x = sums[0][r.index_a][47:0];
                    e.tangent_y = sums[1][r.index_a][47:0];
                    e.tangent_z = sums[2][r.index_a][47:0];
                end
                FUNC_TRI: begin
                    du1 = longint'(tu[r.index_b]) - longint'(tu[r.index_a]);
                    dv1 = longint'(tv[r.index_b]) - longint'(tv[r.index_a]);
                    du2 = longint'(tu[r.index_c]) - longint'(tu[r.index_a]);
                    dv2 = longint'(tv[r.index_c]) - longint'(tv[r.index_a]);
                    det = du1 * dv2 - du2 * dv1;
                    if (det == 0) begin
                        e.status = ST_DEGEN;
                    end else begin
                        sat = 0;
                        corner[0] = r.index_a; corner[1] = r.index_b; corner[2] = r.index_c;
                        for (int k = 0; k < 3; k++) begin
                            p0 = (k == 0) ? px[r.index_a] : (k == 1) ? py[r.index_a] :
                                 pz[r.index_a];
                            d1 = ((k == 0) ? longint'(px[r.index_b]) : (k == 1) ?
                                  longint'(py[r.index_b]) : longint'(pz[r.index_b])) - p0;
                            d2 = ((k == 0) ? longint'(px[r.index_c]) : (k == 1) ?
                                  longint'(py[r.index_c]) : longint'(pz[r.index_c])) - p0;
                            t = tangent_q16(d1 * dv2 - d2 * dv1, det, sat);
                            for (int c = 0; c < 3; c++)
                                sums[k][corner[c]] = clamp_sum(sums[k][corner[c]], t, sat);
                        end
                        e.status = sat ? ST_SAT : ST_OK;
                    end
                end
                default: ;
            endcase
            pending_results.insert(pending_results.size(), e);
        endfunction

        function void check(out_t got);
            out_t e;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            e = pending_results.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected x %h y %h z %h st %0d, got x %h y %h z %h st %0d",
                             e.tangent_x, e.tangent_y, e.tangent_z, e.status,
                             got.tangent_x, got.tangent_y, got.tangent_z, got.status);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 2000000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_t m_data;

    int send_idle_pct = 9;
    int recv_idle_pct = 87;
    bit hold_request = 0;
    int hold_left = 0;
    int cycles = 0;
    int written[$];
    tangent_scoreboard sb;

    triangle_tangent_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver side, with an optional long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_data);
        if (hold_request && hold_left == 0) begin
            hold_left = 400;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send(in_t r);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note(r);
        if (r.func == FUNC_WRITE) written = {written, int'(r.index_a)};
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(8) << 16;
            2: return 32'($signed($urandom_range(400)) - 200) <<< 12;
            default: return $urandom_range(65535);
        endcase
    endfunction

    function automatic in_t vertex(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [31:0] u, logic [31:0] v);
        in_t r;
        r = '0;
        r.func = FUNC_WRITE; r.index_a = IDX_W'(idx);
        r.index_b = IDX_W'($urandom()); r.index_c = IDX_W'($urandom());
        r.pos_x = x; r.pos_y = y; r.pos_z = z; r.tex_u = u; r.tex_v = v;
        return r;
    endfunction

    function automatic in_t cmd(logic [1:0] f, int a, int b, int c);
        in_t r;
        r = '0;
        r.func = f; r.index_a = IDX_W'(a); r.index_b = IDX_W'(b); r.index_c = IDX_W'(c);
        r.pos_x = $urandom(); r.pos_y = $urandom(); r.pos_z = $urandom();
        r.tex_u = $urandom(); r.tex_v = $urandom();
        return r;
    endfunction

    function automatic int pick();
        if ($urandom_range(9) == 0) return written[$urandom_range(written.size() - 1)];
        return written[$urandom_range(written.size() - 1 < 24 ? written.size() - 1 : 23)];
    endfunction

    function automatic in_t random_request();
        int n;
        n = $urandom_range(99);
        if (n < 25 || written.size() < 3) begin
            if ($urandom_range(4) == 0)
                return vertex($urandom_range(1023), coord(), coord(), coord(), coord(), coord());
            return vertex($urandom_range(23), coord(), coord(), coord(), coord(), coord());
        end
        if (n < 70) return cmd(FUNC_TRI, pick(), pick(), pick());
        if (n < 97) return cmd(FUNC_READ, pick(), $urandom(), $urandom());
        return cmd(FUNC_NOP, $urandom(), $urandom(), $urandom());
    endfunction

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed corners
        send(vertex(0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        send(vertex(1, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0));
        send(vertex(2, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000));
        send(vertex(1023, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1));
        send(vertex(1022, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h1, 32'h0));
        send(vertex(3, 32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0002_0000, 32'h0002_0000));
        send(vertex(4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                    32'h8000_0000));
        send(vertex(5, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff));
        send(cmd(FUNC_TRI, 0, 1, 2));
        send(cmd(FUNC_TRI, 0, 1023, 1022));
        send(cmd(FUNC_TRI, 0, 0, 1));
        send(cmd(FUNC_TRI, 0, 2, 3));
        send(cmd(FUNC_TRI, 0, 4, 5));
        send(cmd(FUNC_TRI, 1023, 4, 5));
        send(cmd(FUNC_READ, 0, 0, 0));
        send(cmd(FUNC_READ, 1, 0, 0));
        send(cmd(FUNC_READ, 1023, 0, 0));
        send(cmd(FUNC_READ, 1022, 0, 0));
        send(cmd(FUNC_NOP, 1023, 1023, 1023));
        send(vertex(0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5));
        send(cmd(FUNC_READ, 0, 0, 0));
        written = {0, 1, 2, 3, 4, 5, 1023, 1022};

        for (int i = 0; i < 230; i++) send(random_request());

        send_idle_pct = 87;
        recv_idle_pct = 9;
        hold_request = 1;
        for (int i = 0; i < 20; i++) send(random_request());
        drain();
        for (int i = 0; i < 210; i++) send(random_request());

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 230; i++) send(random_request());

        drain();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ triangle_tangent_accumulator.f @@
sv/tta_pkg.sv
sv/tta_ram.sv
sv/triangle_tangent_accumulator.sv
verif/triangle_tangent_accumulator_tb.sv
